/* hw/rtl/quartic_spline_kernel_eval_macros.svh */
// ---------------------------------------------------------------------------
// quartic spline kernel evaluator - assertion macros
// concurrent checks clocked on clk and held off while rst is high
// ---------------------------------------------------------------------------
`ifndef QUARTIC_SPLINE_KERNEL_EVAL_MACROS_SVH
`define QUARTIC_SPLINE_KERNEL_EVAL_MACROS_SVH

// condition that holds at every clock edge
`define QSKE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition that holds in the cycle after a trigger
`define QSKE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/qske_pkg.sv */
// ---------------------------------------------------------------------------
// qske_pkg
// shared constants and sideband types of the quartic spline kernel evaluator
// ---------------------------------------------------------------------------
`default_nettype none

package qske_pkg;

  // stream and register widths
  localparam int IN_TDATA_W  = 224;
  localparam int OUT_TDATA_W = 128;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // default fraction bits of coordinates and gradient
  localparam int FRAC_BITS_DEF = 16;

  // register map
  localparam logic REG_SUPPORT_RATIO = 1'b0;
  localparam logic [31:0] SUPPORT_RATIO_RESET = 32'd65536;

  // fixed point one in Q1.30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // gradient saturation limits
  localparam logic [31:0] GRAD_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] GRAD_NEG_LIM = 32'h8000_0000;

  // sideband through the square root
  typedef struct packed {
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
    logic [62:0]      den;
    logic             last;
  } sq_tag_t;

  // sideband through the normalising divider
  typedef struct packed {
    logic        in_supp;
    logic        dz;
    logic [62:0] den;
    logic        last;
  } xd_tag_t;

  // sideband through the gradient divider of the x axis
  typedef struct packed {
    logic [30:0] weight;
    logic        in_supp;
    logic        last;
    logic        neg;
  } gd_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/qske_sqrt.sv */
// ---------------------------------------------------------------------------
// qske_sqrt
// pipelined integer square root, one result bit per register stage
// ---------------------------------------------------------------------------
`default_nettype none

module qske_sqrt #(
  parameter int  N_W   = 66,
  parameter type TAG_T = logic
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [N_W-1:0]         radicand,
  input  wire TAG_T                   tag_in,
  output logic                        out_valid,
  output logic [(N_W+1)/2-1:0]        root,
  output TAG_T                        tag_out
);

  localparam int R_W  = (N_W + 1) / 2;
  localparam int NP   = 2 * R_W;
  localparam int RM_W = R_W + 2;

  logic              vld [0:R_W-1];
  logic [NP-1:0]     rad [0:R_W-1];
  logic [R_W-1:0]    rt  [0:R_W-1];
  logic [RM_W-1:0]   rm  [0:R_W-1];
  TAG_T              tg  [0:R_W-1];

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    logic            src_v;
    logic [NP-1:0]   src_rad;
    logic [R_W-1:0]  src_rt;
    logic [RM_W-1:0] src_rm;
    TAG_T            src_tg;
    logic [RM_W+1:0] sh;
    logic [RM_W+1:0] trial;
    logic            ge;

    // stage source: port for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rad = NP'(radicand);
      assign src_rt  = '0;
      assign src_rm  = '0;
      assign src_tg  = tag_in;
    end else begin : g_rest
      assign src_v   = vld[i-1];
      assign src_rad = rad[i-1];
      assign src_rt  = rt[i-1];
      assign src_rm  = rm[i-1];
      assign src_tg  = tg[i-1];
    end

    // bring down the next bit pair and try the next root bit
    assign sh    = {src_rm, src_rad[NP-1 -: 2]};
    assign trial = {2'b00, src_rt, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i] <= src_rad << 2;
        rt[i]  <= {src_rt[R_W-2:0], ge};
        rm[i]  <= ge ? RM_W'(sh - trial) : RM_W'(sh);
        tg[i]  <= src_tg;
      end
    end
  end

  assign out_valid = vld[R_W-1];
  assign root      = rt[R_W-1];
  assign tag_out   = tg[R_W-1];

endmodule

`default_nettype wire

/* hw/rtl/qske_div.sv */
// ---------------------------------------------------------------------------
// qske_div
// pipelined restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
`default_nettype none

module qske_div #(
  parameter int  DEN_W = 63,
  parameter int  Q_W   = 31,
  parameter int  QO_W  = 32,
  parameter type TAG_T = logic
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DEN_W-1:0]  rem_init,
  input  wire logic [Q_W-1:0]    num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire TAG_T              tag_in,
  output logic                   out_valid,
  output logic [QO_W-1:0]        quo,
  output logic                   ovf,
  output TAG_T                   tag_out
);

  logic              vld [0:Q_W-1];
  logic [DEN_W-1:0]  rm  [0:Q_W-1];
  logic [Q_W-1:0]    nm  [0:Q_W-1];
  logic [DEN_W-1:0]  dv  [0:Q_W-1];
  logic [QO_W-1:0]   qq  [0:Q_W-1];
  logic              ov  [0:Q_W-1];
  TAG_T              tg  [0:Q_W-1];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic             src_v;
    logic [DEN_W-1:0] src_rm;
    logic [Q_W-1:0]   src_nm;
    logic [DEN_W-1:0] src_dv;
    logic [QO_W-1:0]  src_qq;
    logic             src_ov;
    TAG_T             src_tg;
    logic [DEN_W:0]   sh;
    logic             ge;

    // stage source: port for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign src_v  = in_valid;
      assign src_rm = rem_init;
      assign src_nm = num;
      assign src_dv = den;
      assign src_qq = '0;
      assign src_ov = 1'b0;
      assign src_tg = tag_in;
    end else begin : g_rest
      assign src_v  = vld[i-1];
      assign src_rm = rm[i-1];
      assign src_nm = nm[i-1];
      assign src_dv = dv[i-1];
      assign src_qq = qq[i-1];
      assign src_ov = ov[i-1];
      assign src_tg = tg[i-1];
    end

    // shift in the next dividend bit and subtract where it fits
    assign sh = {src_rm, src_nm[Q_W-1]};
    assign ge = (sh >= {1'b0, src_dv});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i] <= ge ? DEN_W'(sh - {1'b0, src_dv}) : DEN_W'(sh);
        nm[i] <= src_nm << 1;
        dv[i] <= src_dv;
        qq[i] <= {src_qq[QO_W-2:0], ge};
        // quotient bits pushed out of the top are kept as a sticky flag
        ov[i] <= src_ov | src_qq[QO_W-1];
        tg[i] <= src_tg;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo       = qq[Q_W-1];
  assign ovf       = ov[Q_W-1];
  assign tag_out   = tg[Q_W-1];

endmodule

`default_nettype wire

/* hw/rtl/quartic_spline_kernel_eval.sv */
// ---------------------------------------------------------------------------
// quartic_spline_kernel_eval
// quartic smoothing kernel value and gradient for one neighbour per transfer
// ---------------------------------------------------------------------------
// channel   direction  transfer
// s_*       in         neighbour, evaluation point, kernel size, tlast
// m_*       out        weight, gradient x y z, tlast
// apb       in/out     support ratio register at byte address 0
//
// one transfer is taken per cycle while the result on m_* is not held; the
// path runs through the 33-stage square root, the 31-stage normalising
// divider and the gradient divider with one stage per quotient bit.
// rst clears all stage valid bits and the support ratio to 1.0.
// a held result on m_* freezes every stage with one shared enable.
// ---------------------------------------------------------------------------
`default_nettype none

module quartic_spline_kernel_eval #(
  parameter int FRAC_BITS = qske_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // point_x, point_y, point_z, eval_x, eval_y, eval_z, kernel_size
  input  wire logic [qske_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic                               s_tlast,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // weight, grad_x, grad_y, grad_z
  output logic [qske_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [qske_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [qske_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [qske_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  import qske_pkg::*;

  localparam int GS  = 2 * FRAC_BITS - 14;
  localparam int GQW = 31 + GS;

  `include "quartic_spline_kernel_eval_macros.svh"

  // configuration register
  logic [31:0] support_ratio;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SUPPORT_RATIO);
  assign prdata = (paddr[2] == REG_SUPPORT_RATIO) ? support_ratio : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      support_ratio <= SUPPORT_RATIO_RESET;
    end else if (cfg_wr) begin
      support_ratio <= pwdata;
    end
  end

  // shared pipeline enable
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: differences, magnitudes, h * q_max
  logic [2:0][32:0] d_c;
  logic [2:0][32:0] mag_c;
  logic [62:0]      den_c;
  logic             v1;
  logic [2:0][32:0] mag1;
  logic [2:0]       neg1;
  logic [62:0]      den1;
  logic             last1;

  for (genvar a = 0; a < 3; a++) begin : g_diff
    assign d_c[a]   = {s_tdata[32*a+31], s_tdata[32*a +: 32]}
                    - {s_tdata[32*a+127], s_tdata[32*a+96 +: 32]};
    assign mag_c[a] = d_c[a][32] ? (33'd0 - d_c[a]) : d_c[a];
  end
  assign den_c = 63'(s_tdata[222:192]) * 63'(support_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag_c;
      neg1  <= {d_c[2][32], d_c[1][32], d_c[0][32]};
      den1  <= den_c;
      last1 <= s_tlast;
    end
  end

  // stage 2: squares
  logic             v2;
  logic [2:0][65:0] sq2;
  sq_tag_t          tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq2[a] <= 66'(mag1[a]) * 66'(mag1[a]);
      end
      tag2 <= '{mag: mag1, neg: neg1, den: den1, last: last1};
    end
  end

  // stage 3: sum of squares
  logic        v3;
  logic [65:0] sum3;
  sq_tag_t     tag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= sq2[0] + sq2[1] + sq2[2];
      tag3 <= tag2;
    end
  end

  // distance
  logic        vs;
  logic [32:0] dist_s;
  sq_tag_t     tag_s;

  qske_sqrt #(
    .N_W   (66),
    .TAG_T (sq_tag_t)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .radicand  (sum3),
    .tag_in    (tag3),
    .out_valid (vs),
    .root      (dist_s),
    .tag_out   (tag_s)
  );

  // stage 4: support test
  logic        v4;
  logic [32:0] dist4;
  logic        inside4;
  sq_tag_t     tag4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist4   <= dist_s;
      inside4 <= (63'({dist_s, 16'd0}) < tag_s.den);
      tag4    <= tag_s;
    end
  end

  // normalised distance X = D * 2^46 / den
  logic        vx;
  logic [30:0] xq;
  xd_tag_t     tag_x;

  qske_div #(
    .DEN_W (63),
    .Q_W   (31),
    .QO_W  (31),
    .TAG_T (xd_tag_t)
  ) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .rem_init  (63'({dist4, 15'd0})),
    .num       (31'd0),
    .den       (tag4.den),
    .tag_in    ('{in_supp: inside4, dz: (dist4 == 33'd0), den: tag4.den,
                  last: tag4.last}),
    .out_valid (vx),
    .quo       (xq),
    .ovf       (),
    .tag_out   (tag_x)
  );

  // unit direction per axis u = |d| * 2^30 / D
  logic [2:0][30:0] uq;
  logic [2:0]       negq;

  for (genvar a = 0; a < 3; a++) begin : g_udiv
    qske_div #(
      .DEN_W (33),
      .Q_W   (31),
      .QO_W  (31),
      .TAG_T (logic)
    ) u_udiv (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v4),
      .rem_init  (tag4.mag[a] >> 1),
      .num       ({tag4.mag[a][0], 30'd0}),
      .den       (dist4),
      .tag_in    (tag4.neg[a]),
      .out_valid (),
      .quo       (uq[a]),
      .ovf       (),
      .tag_out   (negq[a])
    );
  end

  // stage 5: m = 1 - X and m^2
  logic [30:0]      m_c;
  logic             v5;
  logic [29:0]      x5;
  logic [30:0]      m5;
  logic [61:0]      mm5;
  logic [2:0][30:0] u5;
  logic [2:0]       neg5;
  xd_tag_t          tag5;

  assign m_c = ONE_Q30 - {1'b0, xq[29:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5   <= xq[29:0];
      m5   <= m_c;
      mm5  <= 62'(m_c) * 62'(m_c);
      // zero distance gives no direction
      u5   <= tag_x.dz ? '0 : uq;
      neg5 <= negq;
      tag5 <= tag_x;
    end
  end

  // stage 6: m^3 and X * m^2
  logic [30:0]      m2_c;
  logic             v6;
  logic [29:0]      x6;
  logic [61:0]      m3p6;
  logic [60:0]      xm2_6;
  logic [2:0][30:0] u6;
  logic [2:0]       neg6;
  xd_tag_t          tag6;

  assign m2_c = mm5[60:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x6    <= x5;
      m3p6  <= 62'(m2_c) * 62'(m5);
      xm2_6 <= 61'(x5) * 61'(m2_c);
      u6    <= u5;
      neg6  <= neg5;
      tag6  <= tag5;
    end
  end

  // stage 7: weight product and t = 12 * X * m^2
  logic [30:0]      m3_c;
  logic [30:0]      a_c;
  logic [34:0]      t_full;
  logic [31:0]      s_c;
  logic             v7;
  logic [62:0]      wp7;
  logic [31:0]      t7;
  logic [2:0][30:0] u7;
  logic [2:0]       neg7;
  xd_tag_t          tag7;

  assign m3_c   = m3p6[60:30];
  assign a_c    = xm2_6[60:30];
  assign t_full = {1'b0, a_c, 3'd0} + {2'd0, a_c, 2'd0};
  assign s_c    = 32'(ONE_Q30) + 32'({x6, 1'b0}) + 32'(x6);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wp7  <= 63'(m3_c) * 63'(s_c);
      t7   <= t_full[31:0];
      u7   <= u6;
      neg7 <= neg6;
      tag7 <= tag6;
    end
  end

  // stage 8: weight and per-axis t * u
  logic [2:0][62:0] pp_c;
  logic             v8;
  logic [30:0]      weight8;
  logic [2:0][30:0] p8;
  logic [2:0]       neg8;
  xd_tag_t          tag8;

  for (genvar a = 0; a < 3; a++) begin : g_tu
    assign pp_c[a] = 63'(t7) * 63'(u7[a]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight8 <= wp7[60:30];
      for (int a = 0; a < 3; a++) begin
        p8[a] <= pp_c[a][60:30];
      end
      neg8 <= neg7;
      tag8 <= tag7;
    end
  end

  // gradient magnitude P * 2^GS / den
  logic             vg;
  logic [2:0][31:0] gq;
  logic [2:0]       gov;
  logic [2:0]       gneg;
  gd_tag_t          tag_g;

  qske_div #(
    .DEN_W (63),
    .Q_W   (GQW),
    .QO_W  (32),
    .TAG_T (gd_tag_t)
  ) u_gdiv_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .rem_init  (63'd0),
    .num       ({p8[0], GS'(0)}),
    .den       (tag8.den),
    .tag_in    ('{weight: weight8, in_supp: tag8.in_supp, last: tag8.last,
                  neg: neg8[0]}),
    .out_valid (vg),
    .quo       (gq[0]),
    .ovf       (gov[0]),
    .tag_out   (tag_g)
  );

  assign gneg[0] = tag_g.neg;

  for (genvar a = 1; a < 3; a++) begin : g_gdiv
    qske_div #(
      .DEN_W (63),
      .Q_W   (GQW),
      .QO_W  (32),
      .TAG_T (logic)
    ) u_gdiv (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v8),
      .rem_init  (63'd0),
      .num       ({p8[a], GS'(0)}),
      .den       (tag8.den),
      .tag_in    (neg8[a]),
      .out_valid (),
      .quo       (gq[a]),
      .ovf       (gov[a]),
      .tag_out   (gneg[a])
    );
  end

  // saturation, sign and support mask
  logic [2:0][31:0] lim_c;
  logic [2:0][31:0] gsat_c;
  logic [2:0][31:0] grad_c;

  for (genvar a = 0; a < 3; a++) begin : g_sat
    assign lim_c[a]  = gneg[a] ? GRAD_POS_LIM : GRAD_NEG_LIM;
    assign gsat_c[a] = (gov[a] || (gq[a] > lim_c[a])) ? lim_c[a] : gq[a];
    // a positive difference points the gradient the other way
    assign grad_c[a] = !tag_g.in_supp ? 32'd0
                     : gneg[a] ? gsat_c[a] : (32'd0 - gsat_c[a]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, grad_c[2], grad_c[1], grad_c[0],
                  tag_g.in_supp ? tag_g.weight : 31'd0};
      m_tlast <= tag_g.last;
    end
  end

  // checks
  `QSKE_ASSERT_ALWAYS(a_weight_range, !m_tvalid || (m_tdata[30:0] <= ONE_Q30), "weight above one")
  `QSKE_ASSERT_NEXT(a_cfg_write, cfg_wr, support_ratio == $past(pwdata), "support ratio write lost")

endmodule

`default_nettype wire

/* tb/sv/tb_quartic_spline_kernel_eval.sv */
// ---------------------------------------------------------------------------
// tb_quartic_spline_kernel_eval
// self-checking bench: streams neighbour points through the kernel evaluator
// under random back-pressure and compares every result with a local predictor
// of the quartic kernel value and saturated gradient
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quartic_spline_kernel_eval;
  import qske_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int GSHIFT = 2 * FRAC - 14;
  localparam int LATENCY = 104 + GSHIFT;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [IN_TDATA_W-1:0] data;
    logic                  last;
  } neighbour_t;

  typedef struct {
    logic [30:0] weight;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic        last;
  } kernel_res_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  neighbour_t  pending_q[$];
  kernel_res_t expected_q[$];
  logic [31:0] ratio_model;
  int send_idle;
  int recv_idle;
  int errors;
  int received;
  int cycles;
  logic in_taken;

  quartic_spline_kernel_eval DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // kernel value and gradient of one neighbour, exact integer arithmetic
  function automatic kernel_res_t kernel_result(logic [IN_TDATA_W-1:0] td, logic lst,
                                                logic [31:0] ratio);
    kernel_res_t r;
    logic [127:0] mag[3];
    logic neg[3];
    logic [127:0] sum, dlen, c, den, rem, x, m, m2, m3, t, u, p, q, lim;
    logic [31:0] g[3];
    longint d;
    int a, i;
    sum = 0;
    for (a = 0; a < 3; a++) begin
      d = longint'($signed(td[32*a +: 32])) - longint'($signed(td[32*(a+3) +: 32]));
      neg[a] = d < 0;
      mag[a] = neg[a] ? 128'(-d) : 128'(d);
      sum = sum + mag[a] * mag[a];
      g[a] = 0;
    end
    dlen = 0;
    for (i = 34; i >= 0; i--) begin
      c = dlen | (128'd1 << i);
      if (c * c <= sum) dlen = c;
    end
    den = 128'(td[222:192]) * 128'(ratio);
    r.weight = 0;
    r.last = lst;
    if ((dlen << 16) < den) begin
      rem = dlen << 16;
      x = 0;
      for (i = 0; i < 30; i++) begin
        rem = rem << 1;
        x = x << 1;
        if (rem >= den) begin
          rem = rem - den;
          x[0] = 1'b1;
        end
      end
      m = (128'd1 << 30) - x;
      m2 = (m * m) >> 30;
      m3 = (m2 * m) >> 30;
      r.weight = 31'((m3 * ((128'd1 << 30) + 3 * x)) >> 30);
      t = 12 * ((x * m2) >> 30);
      for (a = 0; a < 3; a++) begin
        if (dlen != 0 && mag[a] != 0) begin
          u = (mag[a] << 30) / dlen;
          p = (t * u) >> 30;
          q = p / den;
          rem = p % den;
          for (i = 0; i < GSHIFT && q <= (128'd1 << 31); i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
              rem = rem - den;
              q[0] = 1'b1;
            end
          end
          // negative difference gives a positive gradient
          lim = neg[a] ? 128'(GRAD_POS_LIM) : 128'(GRAD_NEG_LIM);
          if (q > lim) q = lim;
          g[a] = neg[a] ? q[31:0] : 32'(-q[31:0]);
        end
      end
    end
    r.gx = g[0];
    r.gy = g[1];
    r.gz = g[2];
    return r;
  endfunction

  function automatic neighbour_t pack_point(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz, logic [31:0] ex,
                                            logic [31:0] ey, logic [31:0] ez,
                                            logic [30:0] ks, logic lst);
    neighbour_t n;
    n.data = {1'b0, ks, ez, ey, ex, pz, py, px};
    n.last = lst;
    return n;
  endfunction

  // random neighbour: mostly at a distance scaled to the kernel size, the rest raw noise
  function automatic neighbour_t random_point();
    logic [31:0] e[3];
    logic [31:0] dv[3];
    logic [30:0] ks;
    int s, a;
    if ($urandom_range(0, 99) < 25)
      return pack_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        31'($urandom), 1'($urandom));
    s = $urandom_range(2, 26);
    for (a = 0; a < 3; a++) begin
      e[a] = $urandom;
      dv[a] = 32'($signed($urandom_range(0, (1 << s))) - (1 << (s - 1)));
    end
    ks = 31'(((1 << s) >> $urandom_range(0, 2)) * $urandom_range(1, 3));
    if (ks == 0) ks = 1;
    return pack_point(e[0] + dv[0], e[1] + dv[1], e[2] + dv[2], e[0], e[1], e[2],
                      ks, 1'($urandom));
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input transfer: record and predict at the sampling edge
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready)
      expected_q.push_back(kernel_result(s_tdata, s_tlast, ratio_model));
  end

  // driver on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        s_tdata <= pending_q[0].data;
        s_tlast <= pending_q[0].last;
        s_tvalid <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with one long hold-off to fill the pipeline
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!hold_done && received >= 100 && pending_q.size() > 0) begin
      hold_done = 1;
      hold_left = 3 * LATENCY;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= recv_idle;
    end
  end

  // output transfer check
  always @(posedge clk) begin
    kernel_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      received <= received + 1;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (m_tdata[30:0] !== exp_r.weight) begin
          $error("weight exp %0d got %0d", exp_r.weight, m_tdata[30:0]);
          errors++;
        end
        if (m_tdata[62:31] !== exp_r.gx) begin
          $error("grad_x exp %0d got %0d", $signed(exp_r.gx), $signed(m_tdata[62:31]));
          errors++;
        end
        if (m_tdata[94:63] !== exp_r.gy) begin
          $error("grad_y exp %0d got %0d", $signed(exp_r.gy), $signed(m_tdata[94:63]));
          errors++;
        end
        if (m_tdata[126:95] !== exp_r.gz) begin
          $error("grad_z exp %0d got %0d", $signed(exp_r.gz), $signed(m_tdata[126:95]));
          errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last_out exp %0d got %0d", exp_r.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // register write: setup then access cycle
  task automatic write_ratio(logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(REG_SUPPORT_RATIO);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    ratio_model = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // stimulus phases
  initial begin
    logic [31:0] ratios[6];
    int idles[6][2];
    int ph, k;
    ratios = '{32'd65536, 32'd1, 32'hFFFF_FFFF, $urandom, 32'h0002_0000, $urandom | 1};
    idles = '{'{12, 67}, '{67, 12}, '{0, 0}, '{12, 67}, '{67, 12}, '{0, 0}};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    received = 0;
    cycles = 0;
    in_taken = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    ratio_model = SUPPORT_RATIO_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // reset value of the ratio is used for the directed part
    send_idle = 12;
    recv_idle = 67;
    // zero distance
    pending_q.push_back(pack_point(5, 6, 7, 5, 6, 7, 31'h1_0000, 0));
    pending_q.push_back(pack_point(0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 1));
    // coordinate extremes, far outside support
    pending_q.push_back(pack_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   31'h7FFF_FFFF, 0));
    pending_q.push_back(pack_point(32'h8000_0000, 32'h7FFF_FFFF, 0,
                                   32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1));
    // zero kernel size
    pending_q.push_back(pack_point(3, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(pack_point(0, 0, 0, 0, 0, 0, 0, 1));
    // gradient saturation in both directions
    pending_q.push_back(pack_point(1, 0, 0, 0, 0, 0, 2, 0));
    pending_q.push_back(pack_point(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 2, 0));
    pending_q.push_back(pack_point(0, 1, 0, 0, 0, 0, 2, 0));
    pending_q.push_back(pack_point(0, 0, 32'hFFFF_FFFF, 0, 0, 0, 2, 1));
    // inside the support and just at its edge
    pending_q.push_back(pack_point(32'h1_0000, 0, 0, 0, 0, 0, 31'h2_0000, 0));
    pending_q.push_back(pack_point(32'h1_0000, 0, 0, 0, 0, 0, 31'h1_0000, 0));
    pending_q.push_back(pack_point(32'h0_FFFF, 0, 0, 0, 0, 0, 31'h1_0000, 0));
    pending_q.push_back(pack_point(32'h4000, 32'hFFFF_C000, 32'h4000, 0, 0, 0,
                                   31'h1_0000, 1));
    pending_q.push_back(pack_point(32'h7FFF_FFFF, 0, 0, 32'h7FFF_0000, 0, 0,
                                   31'h7FFF_FFFF, 0));
    drain();
    for (ph = 0; ph < 6; ph++) begin
      write_ratio(ratios[ph]);
      send_idle = idles[ph][0];
      recv_idle = idles[ph][1];
      for (k = 0; k < 290; k++) pending_q.push_back(random_point());
      drain();
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/qske_pkg.sv
hw/rtl/qske_sqrt.sv
hw/rtl/qske_div.sv
hw/rtl/quartic_spline_kernel_eval.sv
tb/sv/tb_quartic_spline_kernel_eval.sv
